// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define OBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed on result stream");

// Implication form: antecedent then consequent in the same cycle.
`define OBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `OBC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/obc_pkg.sv =====
// Types, codes and helpers of the opaque bounds crop block.
package obc_pkg;

  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned PaletteSize = 256;

  localparam int unsigned SizeW  = 13;  // size register width
  localparam int unsigned CoordW = 12;  // column / row coordinate width
  localparam int unsigned PosW   = 32;  // screen position width
  localparam int unsigned SlotW  = 8;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 144;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ORIGIN_X     = 2'd2,
    REG_ORIGIN_Y     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FUNC_PALETTE = 1'b0,
    FUNC_PIXEL   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_TRANSPARENT = 2'd0,
    ST_TIGHT       = 2'd1,
    ST_CROPPED     = 2'd2
  } status_e;

  // Bounds of a finished bitmap, handed to the result stage.
  typedef struct packed {
    logic              seen;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] col_last;
    logic [CoordW-1:0] row_last;
    logic [PosW-1:0]   org_x;
    logic [PosW-1:0]   org_y;
  } fin_t;

  // Last coordinate for a size register: zero counts as one, above max is max.
  function automatic logic [CoordW-1:0] size_last(logic [SizeW-1:0] sz,
                                                  logic [SizeW-1:0] max_sz);
    logic [SizeW-1:0] m1;
    if (sz == '0) begin
      m1 = '0;
    end else if (sz > max_sz) begin
      m1 = max_sz - SizeW'(1);
    end else begin
      m1 = sz - SizeW'(1);
    end
    return m1[CoordW-1:0];
  endfunction

  // Signed position plus a non-negative offset, clipped at the top of the range.
  function automatic logic [PosW-1:0] sat_add(logic [PosW-1:0] base,
                                              logic [CoordW-1:0] off);
    logic [PosW:0] sum;
    sum = {base[PosW-1], base} + {{(PosW+1-CoordW){1'b0}}, off};
    if (!sum[PosW] && sum[PosW-1]) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end
    return sum[PosW-1:0];
  endfunction

endpackage

// ===== rtl/opaque_bounds_crop_top.sv =====
// Opaque bounds crop: tight bounding box of visible pixels of an indexed bitmap.
// Takes one request per cycle, except that the last pixel of a bitmap is held
// while the finish stage is full and blocked. A request sits in the input stage,
// where the palette mark lookup, the four bound compares and the raster counters
// are resolved; the last pixel of a bitmap then passes through the finish stage
// (status compare, size subtract, saturating position add) to the output
// register. Palette loads take effect for the very next pixel. The visible
// marks sit in flip-flops cleared by reset, so there is no clearing pass.
module opaque_bounds_crop_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_addr_i,
  input  logic [31:0]                  cfg_wdata_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // palette_slot[7:0], palette_alpha[15:8], pixel_index[23:16]
  input  logic [obc_pkg::InDataW-1:0]  s_axis_tdata,
  // func[0]
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // crop_left[11:0], crop_top[23:12], crop_right[35:24], crop_bottom[47:36],
  // new_width[60:48], new_height[73:61], new_x[105:74], new_y[137:106], zero fill
  output logic [obc_pkg::OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]                   m_axis_tuser
);

  localparam int unsigned CW = obc_pkg::CoordW;
  localparam int unsigned SW = obc_pkg::SizeW;
  localparam int unsigned PW = obc_pkg::PosW;

  // configuration registers
  logic [SW-1:0] width_q, height_q;
  logic [PW-1:0] org_x_q, org_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(1);
      height_q <= SW'(1);
      org_x_q  <= '0;
      org_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        obc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[SW-1:0];
        obc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[SW-1:0];
        obc_pkg::REG_ORIGIN_X:     org_x_q  <= cfg_wdata_i;
        obc_pkg::REG_ORIGIN_Y:     org_y_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic                          v0_q;
  logic                          func0_q;
  logic [obc_pkg::SlotW-1:0]     slot0_q, alpha0_q, idx0_q;

  // bitmap state
  logic [obc_pkg::PaletteSize-1:0] marks_q;
  logic [CW-1:0] col_q, row_q;
  logic [CW-1:0] lcol_q, lrow_q, gcol_q, grow_q;
  logic          seen_q;

  // handshakes between stages
  logic s0_res, s0_go, s1_rdy, s1_go, s2_rdy;
  logic v1_q, v2_q;
  obc_pkg::fin_t fin_q, fin_d;

  assign s2_rdy = !v2_q || m_axis_tready;
  assign s1_rdy = !v1_q || s2_rdy;
  assign s1_go  = v1_q && s2_rdy;

  logic          is_pix, vis, last_col, last_px;
  logic [CW-1:0] col_last, row_last;
  logic [CW-1:0] lcol_d, lrow_d, gcol_d, grow_d;

  always_comb begin
    is_pix   = (func0_q == obc_pkg::FUNC_PIXEL);
    col_last = obc_pkg::size_last(width_q, SW'(obc_pkg::MaxWidth));
    row_last = obc_pkg::size_last(height_q, SW'(obc_pkg::MaxHeight));
    vis      = marks_q[idx0_q];
    last_col = col_q >= col_last;
    last_px  = last_col && (row_q >= row_last);

    lcol_d = lcol_q;
    lrow_d = lrow_q;
    gcol_d = gcol_q;
    grow_d = grow_q;
    if (vis) begin
      if (!seen_q) begin
        lcol_d = col_q;
        gcol_d = col_q;
        lrow_d = row_q;
        grow_d = row_q;
      end else begin
        if (col_q < lcol_q) lcol_d = col_q;
        if (col_q > gcol_q) gcol_d = col_q;
        if (row_q < lrow_q) lrow_d = row_q;
        if (row_q > grow_q) grow_d = row_q;
      end
    end

    fin_d.seen     = seen_q || vis;
    fin_d.left     = lcol_d;
    fin_d.top      = lrow_d;
    fin_d.right    = gcol_d;
    fin_d.bottom   = grow_d;
    fin_d.col_last = col_last;
    fin_d.row_last = row_last;
    fin_d.org_x    = org_x_q;
    fin_d.org_y    = org_y_q;

    s0_res = is_pix && last_px;
    s0_go  = v0_q && (!s0_res || s1_rdy);
  end

  assign s_axis_tready = !v0_q || s0_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      v0_q <= 1'b1;
    end else if (s0_go) begin
      v0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func0_q  <= s_axis_tuser;
      slot0_q  <= s_axis_tdata[7:0];
      alpha0_q <= s_axis_tdata[15:8];
      idx0_q   <= s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      lcol_q  <= '0;
      lrow_q  <= '0;
      gcol_q  <= '0;
      grow_q  <= '0;
      seen_q  <= 1'b0;
    end else if (s0_go) begin
      if (!is_pix) begin
        marks_q[slot0_q] <= (alpha0_q != '0);
      end else if (last_px) begin
        col_q  <= '0;
        row_q  <= '0;
        seen_q <= 1'b0;
      end else begin
        lcol_q <= lcol_d;
        lrow_q <= lrow_d;
        gcol_q <= gcol_d;
        grow_q <= grow_d;
        seen_q <= seen_q || vis;
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + CW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // finish stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s0_go && s0_res) begin
      v1_q <= 1'b1;
    end else if (s1_go) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_go && s0_res) begin
      fin_q <= fin_d;
    end
  end

  obc_pkg::status_e status_d;
  logic [CW-1:0]    left_d, top_d, right_d, bottom_d;
  logic [SW-1:0]    nw_d, nh_d;
  logic [PW-1:0]    nx_d, ny_d;

  always_comb begin
    left_d   = fin_q.seen ? fin_q.left   : '0;
    top_d    = fin_q.seen ? fin_q.top    : '0;
    right_d  = fin_q.seen ? fin_q.right  : '0;
    bottom_d = fin_q.seen ? fin_q.bottom : '0;
    nw_d     = fin_q.seen ? ({1'b0, fin_q.right} - {1'b0, fin_q.left} + SW'(1)) : '0;
    nh_d     = fin_q.seen ? ({1'b0, fin_q.bottom} - {1'b0, fin_q.top} + SW'(1)) : '0;
    nx_d     = obc_pkg::sat_add(fin_q.org_x, left_d);
    ny_d     = obc_pkg::sat_add(fin_q.org_y, top_d);
    if (!fin_q.seen) begin
      status_d = obc_pkg::ST_TRANSPARENT;
    end else if (fin_q.left == '0 && fin_q.top == '0 &&
                 fin_q.right == fin_q.col_last && fin_q.bottom == fin_q.row_last) begin
      status_d = obc_pkg::ST_TIGHT;
    end else begin
      status_d = obc_pkg::ST_CROPPED;
    end
  end

  // output register
  logic [obc_pkg::OutDataW-1:0] data2_q;
  logic [1:0]                   user2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s1_go) begin
      v2_q <= 1'b1;
    end else if (m_axis_tready) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      user2_q <= status_d;
      data2_q <= {6'b0, ny_d, nx_d, nh_d, nw_d, bottom_d, right_d, top_d, left_d};
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = data2_q;
  assign m_axis_tuser  = user2_q;

endmodule

// ===== rtl/obc_checker.sv =====
// Port-level checks on the result stream of the opaque bounds crop block.
`include "assert_macros.svh"

module obc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [obc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);

  logic is_transp, is_tight, is_crop;
  assign is_transp = m_axis_tvalid && (m_axis_tuser == obc_pkg::ST_TRANSPARENT);
  assign is_tight  = m_axis_tvalid && (m_axis_tuser == obc_pkg::ST_TIGHT);
  assign is_crop   = m_axis_tvalid && (m_axis_tuser == obc_pkg::ST_CROPPED);

  `OBC_ASSERT(a_stall_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
  `OBC_ASSERT_IMPL(a_status_code, clk_i, rst_ni, m_axis_tvalid, (is_transp || is_tight || is_crop))
  `OBC_ASSERT_IMPL(a_transp_zero, clk_i, rst_ni, is_transp, (m_axis_tdata[73:0] == '0))
  `OBC_ASSERT_IMPL(a_tight_origin, clk_i, rst_ni, is_tight, (m_axis_tdata[23:0] == '0 && m_axis_tdata[73:48] != '0))
  `OBC_ASSERT_IMPL(a_crop_size, clk_i, rst_ni, is_crop, (m_axis_tdata[60:48] != '0 && m_axis_tdata[73:61] != '0 && m_axis_tdata[35:24] >= m_axis_tdata[11:0]))

endmodule

bind opaque_bounds_crop_top obc_checker u_obc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
